// ----- rtl/sla_pkg.sv -----
// Shared types and constants for the semi-Lagrangian advection core.
package sla_pkg;

  localparam int GRID_DIM   = 128;
  localparam int VALUE_BITS = 32;
  localparam int COORD_W    = $clog2(GRID_DIM);
  localparam int FRAC_W     = 16;
  localparam int DTN_W      = 16 + COORD_W;
  localparam int BANK_AW    = 2 * (COORD_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam logic [15:0]      TIME_STEP_RST = 16'd6554;
  localparam logic [COORD_W-1:0] INTERIOR_RST = COORD_W'(126);
  localparam logic [DTN_W-1:0] DTN_RST = DTN_W'(6554 * 126);

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_ROWS      = 2'd1,
    REG_COLS      = 2'd2,
    REG_MODE      = 2'd3
  } reg_idx_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // trace stage to store stage
  typedef struct packed {
    logic               valid;
    logic               action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] c0;
    logic [FRAC_W-1:0]  fr;
    logic [FRAC_W-1:0]  fc;
    value_t             load_a;
    value_t             load_b;
  } trace_word_t;

  // store stage to blend stage
  typedef struct packed {
    logic                         valid;
    logic                         action;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic [FRAC_W-1:0]            fr;
    logic [FRAC_W-1:0]            fc;
    logic                         r0_par;
    logic                         c0_par;
    logic                         r1_off;
    logic                         c1_off;
    logic [NUM_BANKS-1:0][VALUE_BITS-1:0] rd_a;
    logic [NUM_BANKS-1:0][VALUE_BITS-1:0] rd_b;
  } store_word_t;

endpackage

// ----- rtl/semi_lagrangian_advect_core.sv -----
// Top level of the semi-Lagrangian advection core with APB register port.
//
//   channel  direction  handshake               words
//   in_      input      in_valid / in_stall     load or advect, one per cycle unless stalled
//   out_     output     out_valid / out_stall   one per advect, none per load
//   cfg_     APB slave  psel/penable/pready     time_step, rows, cols, mode
//
// One word per cycle sustained while no valid output is stalled.
// Five register stages: scale, clamp/split, four-bank read, column lerp, row lerp.
// The four banks (row and column parity) give all four neighbours in one read.
// rst_n is synchronous; it clears valid bits and loads the config registers with defaults, not the cell store.
// A stalled output freezes the whole pipeline; in_stall follows it.
module semi_lagrangian_advect_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [sla_pkg::COORD_W-1:0]  in_row,
  input  logic [sla_pkg::COORD_W-1:0]  in_col,
  input  sla_pkg::value_t              in_load_value_a,
  input  sla_pkg::value_t              in_load_value_b,
  input  sla_pkg::value_t              in_vel_row,
  input  sla_pkg::value_t              in_vel_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sla_pkg::COORD_W-1:0]  out_row,
  output logic [sla_pkg::COORD_W-1:0]  out_col,
  output sla_pkg::value_t              out_new_value_a,
  output sla_pkg::value_t              out_new_value_b,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [3:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  logic [15:0]                 time_step_r, time_step_nxt;
  logic [sla_pkg::COORD_W-1:0] rows_r, cols_r, rows_nxt, cols_nxt;
  logic                        vector_mode_r, vector_mode_nxt;
  logic [sla_pkg::DTN_W-1:0]   dtn_row_r, dtn_col_r;
  logic                        cfg_wr;
  sla_pkg::reg_idx_t           cfg_idx;
  logic                        adv;

  sla_pkg::trace_word_t        tr;
  sla_pkg::store_word_t        st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = sla_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    time_step_nxt   = time_step_r;
    rows_nxt        = rows_r;
    cols_nxt        = cols_r;
    vector_mode_nxt = vector_mode_r;
    if (cfg_wr) begin
      case (cfg_idx)
        sla_pkg::REG_TIME_STEP: time_step_nxt   = cfg_pwdata[15:0];
        sla_pkg::REG_ROWS:      rows_nxt        = cfg_pwdata[sla_pkg::COORD_W-1:0];
        sla_pkg::REG_COLS:      cols_nxt        = cfg_pwdata[sla_pkg::COORD_W-1:0];
        sla_pkg::REG_MODE:      vector_mode_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // dt * n per axis, loaded at the same edge as the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= sla_pkg::TIME_STEP_RST;
      rows_r        <= sla_pkg::INTERIOR_RST;
      cols_r        <= sla_pkg::INTERIOR_RST;
      vector_mode_r <= 1'b0;
      dtn_row_r     <= sla_pkg::DTN_RST;
      dtn_col_r     <= sla_pkg::DTN_RST;
    end else begin
      time_step_r   <= time_step_nxt;
      rows_r        <= rows_nxt;
      cols_r        <= cols_nxt;
      vector_mode_r <= vector_mode_nxt;
      dtn_row_r     <= time_step_nxt * rows_nxt;
      dtn_col_r     <= time_step_nxt * cols_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      sla_pkg::REG_TIME_STEP: cfg_prdata = {16'h0, time_step_r};
      sla_pkg::REG_ROWS:      cfg_prdata = {{(32-sla_pkg::COORD_W){1'b0}}, rows_r};
      sla_pkg::REG_COLS:      cfg_prdata = {{(32-sla_pkg::COORD_W){1'b0}}, cols_r};
      sla_pkg::REG_MODE:      cfg_prdata = {31'h0, vector_mode_r};
      default:                cfg_prdata = '0;
    endcase
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  sla_trace u_trace (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_action       (in_action),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_load_value_a (in_load_value_a),
    .in_load_value_b (in_load_value_b),
    .in_vel_row      (in_vel_row),
    .in_vel_col      (in_vel_col),
    .dtn_row         (dtn_row_r),
    .dtn_col         (dtn_col_r),
    .n_rows          (rows_r),
    .n_cols          (cols_r),
    .tr              (tr)
  );

  sla_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .vector_mode (vector_mode_r),
    .tr          (tr),
    .st          (st)
  );

  sla_blend u_blend (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .vector_mode     (vector_mode_r),
    .st              (st),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_new_value_a (out_new_value_a),
    .out_new_value_b (out_new_value_b)
  );

  // clamped row position never passes n + 0.5
  a_row_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    tr.valid && tr.action |->
      (tr.r0 < rows_r) || (tr.r0 == rows_r && tr.fr <= 16'h8000))
    else $error("row trace outside clamp range");

  // same for the column axis
  a_col_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    tr.valid && tr.action |->
      (tr.c0 < cols_r) || (tr.c0 == cols_r && tr.fc <= 16'h8000))
    else $error("column trace outside clamp range");

  // lower clamp: row position never below 0.5
  a_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    tr.valid && tr.action && tr.r0 == '0 |-> tr.fr >= 16'h8000)
    else $error("row trace below half cell");

  // scalar mode leaves the second component at zero
  a_scalar_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !vector_mode_r && $stable(vector_mode_r) |-> out_new_value_b == '0)
    else $error("second component nonzero in scalar mode");

endmodule

// ----- rtl/sla_trace.sv -----
// Back-trace: velocity scaling, position clamp and floor/fraction split.
module sla_trace (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic                            in_action,
  input  logic [sla_pkg::COORD_W-1:0]     in_row,
  input  logic [sla_pkg::COORD_W-1:0]     in_col,
  input  sla_pkg::value_t                 in_load_value_a,
  input  sla_pkg::value_t                 in_load_value_b,
  input  sla_pkg::value_t                 in_vel_row,
  input  sla_pkg::value_t                 in_vel_col,
  input  logic [sla_pkg::DTN_W-1:0]       dtn_row,
  input  logic [sla_pkg::DTN_W-1:0]       dtn_col,
  input  logic [sla_pkg::COORD_W-1:0]     n_rows,
  input  logic [sla_pkg::COORD_W-1:0]     n_cols,
  output sla_pkg::trace_word_t            tr
);

  localparam int PROD_W = sla_pkg::DTN_W + 1 + sla_pkg::VALUE_BITS;
  localparam int DISP_W = PROD_W - sla_pkg::FRAC_W;
  localparam int POS_W  = DISP_W + 2;
  localparam int CLP_W  = sla_pkg::COORD_W + sla_pkg::FRAC_W;

  logic                        v1_r;
  logic                        act1_r;
  logic [sla_pkg::COORD_W-1:0] row1_r, col1_r;
  sla_pkg::value_t             la1_r, lb1_r;
  logic signed [PROD_W-1:0]    prod_r_r, prod_c_r;

  sla_pkg::trace_word_t        tr_r, tr_nxt;
  logic [CLP_W-1:0]            pos_r, pos_c;

  function automatic logic [CLP_W-1:0] clamp_pos(
    input logic [sla_pkg::COORD_W-1:0] coord,
    input logic [sla_pkg::COORD_W-1:0] n,
    input logic signed [PROD_W-1:0]    prod
  );
    logic signed [DISP_W-1:0] disp;
    logic signed [POS_W-1:0]  pos;
    logic signed [POS_W-1:0]  hi;
    logic signed [POS_W-1:0]  lo;
    logic [CLP_W-1:0]         res;
    disp = prod[PROD_W-1:sla_pkg::FRAC_W];
    pos  = $signed({{(POS_W-CLP_W){1'b0}}, coord, {sla_pkg::FRAC_W{1'b0}}})
           - $signed({{2{disp[DISP_W-1]}}, disp});
    hi   = $signed({{(POS_W-CLP_W){1'b0}}, n, 1'b1, {(sla_pkg::FRAC_W-1){1'b0}}});
    lo   = $signed({{(POS_W-sla_pkg::FRAC_W){1'b0}}, 1'b1,
                    {(sla_pkg::FRAC_W-1){1'b0}}});
    if (pos < lo) begin
      res = lo[CLP_W-1:0];
    end else if (pos > hi) begin
      res = hi[CLP_W-1:0];
    end else begin
      res = pos[CLP_W-1:0];
    end
    return res;
  endfunction

  // stage 1: scale velocity by dt * n
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1_r   <= in_action;
      row1_r   <= in_row;
      col1_r   <= in_col;
      la1_r    <= in_load_value_a;
      lb1_r    <= in_load_value_b;
      prod_r_r <= $signed({1'b0, dtn_row}) * in_vel_row;
      prod_c_r <= $signed({1'b0, dtn_col}) * in_vel_col;
    end
  end

  // stage 2: subtract displacement, clamp, split
  always_comb begin
    pos_r          = clamp_pos(row1_r, n_rows, prod_r_r);
    pos_c          = clamp_pos(col1_r, n_cols, prod_c_r);
    tr_nxt.valid   = v1_r;
    tr_nxt.action  = act1_r;
    tr_nxt.row     = row1_r;
    tr_nxt.col     = col1_r;
    tr_nxt.r0      = pos_r[CLP_W-1:sla_pkg::FRAC_W];
    tr_nxt.c0      = pos_c[CLP_W-1:sla_pkg::FRAC_W];
    tr_nxt.fr      = pos_r[sla_pkg::FRAC_W-1:0];
    tr_nxt.fc      = pos_c[sla_pkg::FRAC_W-1:0];
    tr_nxt.load_a  = la1_r;
    tr_nxt.load_b  = lb1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_r.valid <= 1'b0;
    end else if (adv) begin
      tr_r <= tr_nxt;
    end
  end

  assign tr = tr_r;

endmodule

// ----- rtl/sla_store.sv -----
// Four-bank cell store: loads write, advects read all four neighbours at once.
module sla_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vector_mode,
  input  sla_pkg::trace_word_t tr,
  output sla_pkg::store_word_t st
);

  localparam int CW = sla_pkg::COORD_W;

  logic                     we;
  logic [1:0]               wbank;
  logic [sla_pkg::BANK_AW-1:0] waddr;

  logic                     v_r, act_r, r0p_r, c0p_r, r1o_r, c1o_r;
  logic [CW-1:0]            row_r, col_r;
  logic [sla_pkg::FRAC_W-1:0] fr_r, fc_r;
  logic [sla_pkg::NUM_BANKS-1:0][sla_pkg::VALUE_BITS-1:0] rd_a, rd_b;

  assign we    = adv && tr.valid && !tr.action;
  assign wbank = {tr.row[0], tr.col[0]};
  assign waddr = {tr.row[CW-1:1], tr.col[CW-1:1]};

  for (genvar g = 0; g < sla_pkg::NUM_BANKS; g++) begin : g_bank
    localparam logic BR = 1'((g >> 1) & 1);
    localparam logic BC = 1'(g & 1);

    logic [sla_pkg::VALUE_BITS-1:0] mem_a [sla_pkg::BANK_DEPTH];
    logic [sla_pkg::VALUE_BITS-1:0] mem_b [sla_pkg::BANK_DEPTH];
    logic [sla_pkg::VALUE_BITS-1:0] rd_a_r, rd_b_r;
    logic [CW:0]                    rsel, csel;
    logic [sla_pkg::BANK_AW-1:0]    raddr;

    // this bank holds whichever of r0, r0+1 has its parity
    assign rsel  = (tr.r0[0] == BR) ? {1'b0, tr.r0} : {1'b0, tr.r0} + 1'b1;
    assign csel  = (tr.c0[0] == BC) ? {1'b0, tr.c0} : {1'b0, tr.c0} + 1'b1;
    assign raddr = {rsel[CW-1:1], csel[CW-1:1]};

    always_ff @(posedge clk) begin
      if (we && wbank == 2'(g)) begin
        mem_a[waddr] <= tr.load_a;
        if (vector_mode) begin
          mem_b[waddr] <= tr.load_b;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_a_r <= mem_a[raddr];
        rd_b_r <= mem_b[raddr];
      end
    end

    assign rd_a[g] = rd_a_r;
    assign rd_b[g] = rd_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= tr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_r <= tr.action;
      row_r <= tr.row;
      col_r <= tr.col;
      fr_r  <= tr.fr;
      fc_r  <= tr.fc;
      r0p_r <= tr.r0[0];
      c0p_r <= tr.c0[0];
      r1o_r <= (tr.r0 == CW'(sla_pkg::GRID_DIM - 1));
      c1o_r <= (tr.c0 == CW'(sla_pkg::GRID_DIM - 1));
    end
  end

  always_comb begin
    st.valid  = v_r;
    st.action = act_r;
    st.row    = row_r;
    st.col    = col_r;
    st.fr     = fr_r;
    st.fc     = fc_r;
    st.r0_par = r0p_r;
    st.c0_par = c0p_r;
    st.r1_off = r1o_r;
    st.c1_off = c1o_r;
    st.rd_a   = rd_a;
    st.rd_b   = rd_b;
  end

endmodule

// ----- rtl/sla_blend.sv -----
// Bilinear blend: column-axis lerps, then the row-axis lerp and output register.
module sla_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         vector_mode,
  input  sla_pkg::store_word_t         st,
  output logic                         out_valid,
  output logic [sla_pkg::COORD_W-1:0]  out_row,
  output logic [sla_pkg::COORD_W-1:0]  out_col,
  output sla_pkg::value_t              out_new_value_a,
  output sla_pkg::value_t              out_new_value_b
);

  localparam int VB = sla_pkg::VALUE_BITS;
  localparam int FW = sla_pkg::FRAC_W;

  function automatic sla_pkg::value_t lerp(
    input logic [FW-1:0]  f,
    input sla_pkg::value_t a,
    input sla_pkg::value_t b
  );
    logic signed [VB:0]         d;
    logic signed [VB+FW+1:0]    p;
    logic signed [VB+1:0]       s;
    d = $signed({b[VB-1], b}) - $signed({a[VB-1], a});
    p = $signed({1'b0, f}) * d;
    s = $signed({{2{a[VB-1]}}, a}) + p[VB+FW+1:FW];
    return s[VB-1:0];
  endfunction

  sla_pkg::value_t nb_a [4];
  sla_pkg::value_t nb_b [4];

  logic                         v4_r;
  logic [sla_pkg::COORD_W-1:0]  row4_r, col4_r;
  logic [FW-1:0]                fr4_r;
  sla_pkg::value_t              top_a_r, bot_a_r, top_b_r, bot_b_r;

  logic                         v5_r;
  logic [sla_pkg::COORD_W-1:0]  row5_r, col5_r;
  sla_pkg::value_t              va5_r, vb5_r;

  // neighbour k = {dr, dc}; off-grid ones read zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic dr, dc;
      logic [1:0] bk;
      dr = k[1];
      dc = k[0];
      bk = {st.r0_par ^ dr, st.c0_par ^ dc};
      if ((dr && st.r1_off) || (dc && st.c1_off)) begin
        nb_a[k] = '0;
        nb_b[k] = '0;
      end else begin
        nb_a[k] = st.rd_a[bk];
        nb_b[k] = st.rd_b[bk];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= st.valid && st.action;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row4_r  <= st.row;
      col4_r  <= st.col;
      fr4_r   <= st.fr;
      top_a_r <= lerp(st.fc, nb_a[0], nb_a[1]);
      bot_a_r <= lerp(st.fc, nb_a[2], nb_a[3]);
      top_b_r <= lerp(st.fc, nb_b[0], nb_b[1]);
      bot_b_r <= lerp(st.fc, nb_b[2], nb_b[3]);
      row5_r  <= row4_r;
      col5_r  <= col4_r;
      va5_r   <= lerp(fr4_r, top_a_r, bot_a_r);
      vb5_r   <= vector_mode ? lerp(fr4_r, top_b_r, bot_b_r) : '0;
    end
  end

  assign out_valid       = v5_r;
  assign out_row         = row5_r;
  assign out_col         = col5_r;
  assign out_new_value_a = va5_r;
  assign out_new_value_b = vb5_r;

endmodule

// ----- tb/semi_lagrangian_advect_core_test.sv -----
// Self-checking testbench for the semi-Lagrangian advection core: bilinear trace-back results.
`timescale 1ns / 100ps

module semi_lagrangian_advect_core_test;

  // advects only ever read inside this square, plus the far corner
  localparam int FILL = 16;

  typedef struct {
    logic        action;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [31:0] load_a;
    logic [31:0] load_b;
    logic [31:0] vel_r;
    logic [31:0] vel_c;
  } cell_word_t;

  typedef struct {
    logic [6:0]  row;
    logic [6:0]  col;
    logic [31:0] val_a;
    logic [31:0] val_b;
  } advect_result_t;

  class advect_scoreboard;
    logic [31:0]    grid_a[sla_pkg::GRID_DIM*sla_pkg::GRID_DIM];
    logic [31:0]    grid_b[sla_pkg::GRID_DIM*sla_pkg::GRID_DIM];
    longint         step_q16;
    longint         rows_n;
    longint         cols_n;
    bit             vec_mode;
    advect_result_t pending_q[$];
    int             mismatches;
    int             results_seen;
    int             loads_seen;

    function new();
      step_q16 = 6554;
      rows_n = 126;
      cols_n = 126;
      vec_mode = 0;
      mismatches = 0;
      results_seen = 0;
      loads_seen = 0;
    endfunction

    function void set_reg(sla_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        sla_pkg::REG_TIME_STEP: step_q16 = v[15:0];
        sla_pkg::REG_ROWS:      rows_n = v[6:0];
        sla_pkg::REG_COLS:      cols_n = v[6:0];
        sla_pkg::REG_MODE:      vec_mode = v[0];
        default: ;
      endcase
    endfunction

    // a + floor(t*(b-a)/2^16)
    function longint lerp16(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> 16);
    endfunction

    function longint trace_back(longint coord, longint n, logic signed [31:0] vel);
      longint dtn;
      longint pos;
      longint hi;
      dtn = step_q16 * n;
      pos = coord * 65536 - ((dtn * longint'(vel)) >>> 16);
      hi = n * 65536 + 32768;
      if (pos < 32768) pos = 32768;
      if (pos > hi) pos = hi;
      return pos;
    endfunction

    function longint fetch(longint r, longint c, bit second);
      if (r >= sla_pkg::GRID_DIM || c >= sla_pkg::GRID_DIM) return 0;
      if (second) return longint'($signed(grid_b[r*sla_pkg::GRID_DIM + c]));
      return longint'($signed(grid_a[r*sla_pkg::GRID_DIM + c]));
    endfunction

    function longint blend(longint r0, longint c0, longint fr, longint fc, bit second);
      longint upper;
      longint lower;
      upper = lerp16(fc, fetch(r0, c0, second), fetch(r0, c0 + 1, second));
      lower = lerp16(fc, fetch(r0 + 1, c0, second), fetch(r0 + 1, c0 + 1, second));
      return lerp16(fr, upper, lower);
    endfunction

    function void note_word(cell_word_t w);
      longint pr;
      longint pc;
      longint va;
      longint vb;
      advect_result_t res;
      if (!w.action) begin
        grid_a[w.row*sla_pkg::GRID_DIM + w.col] = w.load_a;
        if (vec_mode) grid_b[w.row*sla_pkg::GRID_DIM + w.col] = w.load_b;
        loads_seen++;
        return;
      end
      pr = trace_back(w.row, rows_n, w.vel_r);
      pc = trace_back(w.col, cols_n, w.vel_c);
      va = blend(pr >> 16, pc >> 16, pr & 16'hFFFF, pc & 16'hFFFF, 0);
      vb = vec_mode ? blend(pr >> 16, pc >> 16, pr & 16'hFFFF, pc & 16'hFFFF, 1) : 0;
      res.row = w.row;
      res.col = w.col;
      res.val_a = va[31:0];
      res.val_b = vb[31:0];
      pending_q.push_back(res);
    endfunction

    function void check_word(advect_result_t got);
      advect_result_t exp_r;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result row %0d col %0d a %h b %h",
                   got.row, got.col, got.val_a, got.val_b);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.row !== exp_r.row || got.col !== exp_r.col ||
          got.val_a !== exp_r.val_a || got.val_b !== exp_r.val_b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp r%0d c%0d a %h b %h / got r%0d c%0d a %h b %h",
                   exp_r.row, exp_r.col, exp_r.val_a, exp_r.val_b,
                   got.row, got.col, got.val_a, got.val_b);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_stall;
  logic             in_action = 0;
  logic [6:0]       in_row = 0;
  logic [6:0]       in_col = 0;
  sla_pkg::value_t  in_load_value_a = 0;
  sla_pkg::value_t  in_load_value_b = 0;
  sla_pkg::value_t  in_vel_row = 0;
  sla_pkg::value_t  in_vel_col = 0;
  logic             out_valid;
  logic             out_stall = 0;
  logic [6:0]       out_row;
  logic [6:0]       out_col;
  sla_pkg::value_t  out_new_value_a;
  sla_pkg::value_t  out_new_value_b;
  logic             cfg_psel = 0;
  logic             cfg_penable = 0;
  logic             cfg_pwrite = 0;
  logic [3:0]       cfg_paddr = 0;
  logic [31:0]      cfg_pwdata = 0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  advect_scoreboard sb = new();
  bit no_gaps = 1;
  int stall_hold = 0;
  int advects_sent = 0;

  semi_lagrangian_advect_core u_top (.*);

  always #6 clk = ~clk;

  initial begin
    #(12 * 3000000);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls: mostly short, now and then a long hold
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n || no_gaps) begin
      out_stall <= 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
      out_stall <= 1;
    end else if (r < 2) begin
      stall_hold = $urandom_range(10, 40);
      out_stall <= 1;
    end else begin
      out_stall <= (r < 22);
    end
  end

  // handshake signals settle between edges, so sample at the falling edge
  always @(negedge clk) begin
    advect_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.row = out_row;
      got.col = out_col;
      got.val_a = out_new_value_a;
      got.val_b = out_new_value_b;
      sb.check_word(got);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 8 << 16) - (4 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 20 << 16) - (10 << 16);
      default: return $urandom;
    endcase
  endfunction

  // entered just after a rising edge; returns just after the accepting edge
  task automatic send_word(cell_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= w.action;
    in_row <= w.row;
    in_col <= w.col;
    in_load_value_a <= w.load_a;
    in_load_value_b <= w.load_b;
    in_vel_row <= w.vel_r;
    in_vel_col <= w.vel_c;
    do @(negedge clk); while (in_stall);
    sb.note_word(w);
    if (w.action) advects_sent++;
    @(posedge clk);
  endtask

  task automatic send_load(logic [6:0] r, logic [6:0] c, logic [31:0] a, logic [31:0] b);
    cell_word_t w;
    w = '{1'b0, r, c, a, b, $urandom, $urandom};
    send_word(w);
  endtask

  task automatic send_advect(logic [6:0] r, logic [6:0] c, logic [31:0] vr, logic [31:0] vc);
    cell_word_t w;
    w = '{1'b1, r, c, $urandom, $urandom, vr, vc};
    send_word(w);
  endtask

  // idle the input and wait out the pipeline, loads included
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(sla_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [15:0] ts, logic [6:0] nr, logic [6:0] nc, bit vm);
    write_reg(sla_pkg::REG_TIME_STEP, 32'(ts));
    write_reg(sla_pkg::REG_ROWS, 32'(nr));
    write_reg(sla_pkg::REG_COLS, 32'(nc));
    write_reg(sla_pkg::REG_MODE, 32'(vm));
  endtask

  // interior sizes keep every read inside the loaded square
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 4))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'(FILL - 2);
      default: return 7'($urandom_range(1, FILL - 2));
    endcase
  endfunction

  initial begin
    int n_phase;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // every cell an advect can reach gets both components first
    write_reg(sla_pkg::REG_MODE, 32'd1);
    for (int r = 0; r < FILL; r++)
      for (int c = 0; c < FILL; c++)
        send_load(7'(r), 7'(c), rand_value(), rand_value());
    for (int r = 126; r < 128; r++)
      for (int c = 126; c < 128; c++)
        send_load(7'(r), 7'(c), rand_value(), rand_value());
    drain();

    // directed: field extremes, corners, zero step, scalar load over vector data
    configure(16'hFFFF, 7'd126, 7'd126, 1'b1);
    send_advect(7'd0, 7'd0, 32'h0, 32'h0);
    send_advect(7'd127, 7'd127, 32'h0, 32'h0);
    send_advect(7'd127, 7'd127, 32'hFFFF0000, 32'hFFFF0000);
    send_advect(7'd5, 7'd5, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_advect(7'd10, 7'd3, 32'h00000100, 32'h00000040);
    send_load(7'd5, 7'd5, 32'h7FFFFFFF, 32'h80000000);
    send_load(7'd5, 7'd6, 32'h80000000, 32'h7FFFFFFF);
    send_advect(7'd5, 7'd5, 32'h00000010, 32'hFFFFFFF0);
    send_advect(7'd14, 7'd0, 32'h00000100, 32'hFFFFFF00);
    drain();
    configure(16'h0000, 7'd1, 7'd126, 1'b0);
    send_load(7'd3, 7'd3, 32'h12345678, 32'h0BADF00D);
    send_advect(7'd3, 7'd3, $urandom, $urandom);
    send_advect(7'd127, 7'd9, 32'h7FFFFFFF, 32'h7FFFFFFF);
    drain();
    configure(16'h8000, 7'd0, 7'd0, 1'b1);
    send_advect(7'd0, 7'd127, 32'h80000000, 32'h80000000);
    send_advect(7'd90, 7'd17, rand_vel(), rand_vel());
    send_advect(7'd17, 7'd90, 32'h0, 32'h0);
    drain();

    // random phases; loads and advects mixed
    no_gaps = 0;
    n_phase = 10;
    for (int p = 0; p < n_phase; p++) begin
      logic [15:0] ts;
      case ($urandom_range(0, 3))
        0: ts = 16'h0000;
        1: ts = 16'hFFFF;
        default: ts = 16'($urandom_range(0, 16'hFFFF));
      endcase
      configure(ts, pick_size(), pick_size(), 1'($urandom_range(0, 1)));
      no_gaps = (p == 3);
      for (int i = 0; i < 38; i++) begin
        if (p == 5 && i == 30) drain();
        if ($urandom_range(0, 99) < 30)
          send_load(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), rand_value(),
                    rand_value());
        else
          send_advect(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), rand_vel(),
                      rand_vel());
      end
      drain();
    end

    $display("Covered %0d loads and %0d advects over %0d register settings, %0d results.",
             sb.loads_seen, advects_sent, n_phase + 4, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches %0d, results still owed %0d", sb.mismatches, sb.pending_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
